FILE: rtl/core/compass_heading_from_xy_defines.svh
// ----------------------------------------------------------------------------
// Compass heading assertion macros
// Shared property forms for the checker that watches the heading block ports.
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_FROM_XY_DEFINES_SVH
`define COMPASS_HEADING_FROM_XY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define CHEAD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define CHEAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the next cycle, checked during reset as well.
`define CHEAD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/chead_pkg.sv
// ----------------------------------------------------------------------------
// Compass heading package
// Shared widths, angle constants, the arctangent table and pipeline control.
// ----------------------------------------------------------------------------
package chead_pkg;

  // Default sizes of the datapath.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int SAMPLE_BITS_DEF   = 12;

  // Samples enter the CORDIC scaled by 2^FRAC_BITS.
  localparam int FRAC_BITS = 24;

  // Angle accumulator in 1/16384 degree, result in 1/64 degree.
  localparam int ZW        = 25;
  localparam int ANG_SHIFT = 8;
  localparam int AW        = ZW + 1 - ANG_SHIFT;
  localparam int DW        = 15;
  localparam int HW        = 15;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] DEG90   = ZW'(90 * 64 * 256);
  localparam logic signed [ZW-1:0] DEG180  = ZW'(180 * 64 * 256);
  localparam logic signed [ZW-1:0] ROUND_C = ZW'(1 << (ANG_SHIFT - 1));

  localparam logic signed [AW-1:0] FULL_TURN  = AW'(23040);
  localparam logic signed [DW-1:0] DECL_LIMIT = DW'(11520);

  // Pipeline control that travels with every item.
  typedef struct packed {
    logic vld;   // stage holds an item
    logic spec;  // axis or origin case: angle is final, rotations skip it
  } chead_ctl_t;

  // atan(2^-i) in 1/16384 degree, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = ZW'(737280);
      1:       v = ZW'(435242);
      2:       v = ZW'(229970);
      3:       v = ZW'(116736);
      4:       v = ZW'(58595);
      5:       v = ZW'(29326);
      6:       v = ZW'(14667);
      7:       v = ZW'(7334);
      8:       v = ZW'(3667);
      9:       v = ZW'(1833);
      10:      v = ZW'(917);
      11:      v = ZW'(458);
      12:      v = ZW'(229);
      13:      v = ZW'(115);
      14:      v = ZW'(57);
      15:      v = ZW'(29);
      16:      v = ZW'(14);
      17:      v = ZW'(7);
      18:      v = ZW'(4);
      19:      v = ZW'(2);
      20:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/chead_prep.sv
// ----------------------------------------------------------------------------
// Compass heading input stage
// Scales the sample pair, folds the left half-plane and resolves axis cases.
// ----------------------------------------------------------------------------
module chead_prep #(
  parameter int SAMPLE_BITS = chead_pkg::SAMPLE_BITS_DEF,
  parameter int W           = chead_pkg::SAMPLE_BITS_DEF + chead_pkg::FRAC_BITS + 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_vld,
  output logic                              up_rdy,
  input  logic signed [SAMPLE_BITS-1:0]     x_i,
  input  logic signed [SAMPLE_BITS-1:0]     y_i,
  input  logic                              dn_rdy,
  output chead_pkg::chead_ctl_t             ctl_o,
  output logic signed [W-1:0]               x_o,
  output logic signed [W-1:0]               y_o,
  output logic signed [chead_pkg::ZW-1:0]   z_o
);
  import chead_pkg::*;

  chead_ctl_t           ctl_r;
  logic                 spec_nxt;
  logic signed [W-1:0]  x_ext, y_ext;
  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 x_neg, y_neg, x_zero, y_zero;

  // Sign-extend and scale both samples.
  assign x_ext  = {{(W - SAMPLE_BITS - FRAC_BITS){x_i[SAMPLE_BITS-1]}}, x_i,
                   {FRAC_BITS{1'b0}}};
  assign y_ext  = {{(W - SAMPLE_BITS - FRAC_BITS){y_i[SAMPLE_BITS-1]}}, y_i,
                   {FRAC_BITS{1'b0}}};
  assign x_neg  = x_i[SAMPLE_BITS-1];
  assign y_neg  = y_i[SAMPLE_BITS-1];
  assign x_zero = (x_i == '0);
  assign y_zero = (y_i == '0);

  // Axis cases give the exact angle; the left half-plane is turned by 180 degrees.
  always_comb begin
    spec_nxt = 1'b0;
    x_nxt    = x_ext;
    y_nxt    = y_ext;
    z_nxt    = '0;
    if (x_zero && y_zero) begin
      spec_nxt = 1'b1;
    end else if (y_zero) begin
      spec_nxt = 1'b1;
      z_nxt    = x_neg ? DEG180 : '0;
    end else if (x_zero) begin
      spec_nxt = 1'b1;
      z_nxt    = y_neg ? -DEG90 : DEG90;
    end else if (x_neg) begin
      x_nxt = -x_ext;
      y_nxt = -y_ext;
      z_nxt = y_neg ? -DEG180 : DEG180;
    end
  end

  assign up_rdy = !ctl_r.vld || dn_rdy;

  // Stage register; the valid bit follows the handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_rdy) begin
      ctl_r.vld  <= up_vld;
      ctl_r.spec <= spec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

FILE: rtl/core/chead_cordic_stage.sv
// ----------------------------------------------------------------------------
// Compass heading CORDIC stage
// One registered vectoring rotation by atan(2^-STAGE).
// ----------------------------------------------------------------------------
module chead_cordic_stage #(
  parameter int STAGE = 0,
  parameter int W     = chead_pkg::SAMPLE_BITS_DEF + chead_pkg::FRAC_BITS + 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  chead_pkg::chead_ctl_t             ctl_i,
  output logic                              up_rdy,
  input  logic signed [W-1:0]               x_i,
  input  logic signed [W-1:0]               y_i,
  input  logic signed [chead_pkg::ZW-1:0]   z_i,
  input  logic                              dn_rdy,
  output chead_pkg::chead_ctl_t             ctl_o,
  output logic signed [W-1:0]               x_o,
  output logic signed [W-1:0]               y_o,
  output logic signed [chead_pkg::ZW-1:0]   z_o
);
  import chead_pkg::*;

  localparam logic signed [ZW-1:0] ATAN_C = atan_entry(STAGE);

  chead_ctl_t           ctl_r;
  logic signed [W-1:0]  xs, ys;
  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;

  // Arithmetic shifts round toward minus infinity.
  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  // Rotate toward the X axis unless the angle is already final.
  always_comb begin
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (!ctl_i.spec) begin
      if (y_i[W-1]) begin
        x_nxt = x_i - ys;
        y_nxt = y_i + xs;
        z_nxt = z_i - ATAN_C;
      end else begin
        x_nxt = x_i + ys;
        y_nxt = y_i - xs;
        z_nxt = z_i + ATAN_C;
      end
    end
  end

  assign up_rdy = !ctl_r.vld || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_rdy) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && ctl_i.vld) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

FILE: rtl/core/chead_finish.sv
// ----------------------------------------------------------------------------
// Compass heading output stages
// Rounds the angle to 1/64 degree, adds declination and wraps into one turn.
// ----------------------------------------------------------------------------
module chead_finish (
  input  logic                              clk,
  input  logic                              rst_n,
  input  chead_pkg::chead_ctl_t             ctl_i,
  output logic                              up_rdy,
  input  logic signed [chead_pkg::ZW-1:0]   z_i,
  input  logic signed [chead_pkg::DW-1:0]   decl_i,
  input  logic                              dn_rdy,
  output logic                              out_vld,
  output logic [chead_pkg::HW-1:0]          heading_o
);
  import chead_pkg::*;

  logic                 sum_vld_r, out_vld_r;
  logic                 sum_rdy, out_rdy;
  logic signed [ZW:0]   z_round;
  logic signed [AW-1:0] ang;
  logic signed [AW-1:0] sum_r, sum_nxt;
  logic signed [AW-1:0] wrap;
  logic [HW-1:0]        heading_r;

  // Round half up to 1/64 degree, then add the declination.
  assign z_round = {z_i[ZW-1], z_i} + {ROUND_C[ZW-1], ROUND_C};
  assign ang     = z_round[ZW:ANG_SHIFT];
  assign sum_nxt = ang + {{(AW - DW){decl_i[DW-1]}}, decl_i};

  // One wrap into 0..360 degrees; exactly 360 is kept.
  always_comb begin
    wrap = sum_r;
    if (sum_r[AW-1]) begin
      wrap = sum_r + FULL_TURN;
    end else if (sum_r > FULL_TURN) begin
      wrap = sum_r - FULL_TURN;
    end
  end

  assign out_rdy = !out_vld_r || dn_rdy;
  assign sum_rdy = !sum_vld_r || out_rdy;
  assign up_rdy  = sum_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (sum_rdy) begin
        sum_vld_r <= ctl_i.vld;
      end
      if (out_rdy) begin
        out_vld_r <= sum_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_rdy && ctl_i.vld) begin
      sum_r <= sum_nxt;
    end
    if (out_rdy && sum_vld_r) begin
      heading_r <= wrap[HW-1:0];
    end
  end

  assign out_vld   = out_vld_r;
  assign heading_o = heading_r;

endmodule

FILE: rtl/core/compass_heading_from_xy.sv
// Each item passes the input stage register, the CORDIC stage registers, then the sum and output registers.
// Throughput: one item per cycle while not stalled; each rotation has its own stage.
// Each stage holds its item while the next is full, so a stall loses nothing.
// Reset (synchronous, rst_n low) empties the pipeline and sets declination to 0.
// ----------------------------------------------------------------------------
// Compass heading from magnetometer X,Y
// Pipelined vectoring CORDIC atan2 with declination offset and 360 degree wrap.
// ----------------------------------------------------------------------------
module compass_heading_from_xy #(
  parameter int CORDIC_STAGES = chead_pkg::CORDIC_STAGES_DEF,
  parameter int SAMPLE_BITS   = chead_pkg::SAMPLE_BITS_DEF,
  parameter int IN_BYTES_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input item.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_BYTES_W-1:0]         in_tdata,   // x_component, y_component, zero pad
  // Result item.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // heading[14:0], zero pad
  // Declination register.
  input  logic                          cfg_we,
  input  logic [chead_pkg::DW-1:0]      cfg_wdata
);
  import chead_pkg::*;

  localparam int W = SAMPLE_BITS + FRAC_BITS + 2;

  chead_ctl_t           ctl_s [CORDIC_STAGES+1];
  logic signed [W-1:0]  x_s   [CORDIC_STAGES+1];
  logic signed [W-1:0]  y_s   [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_s   [CORDIC_STAGES+1];
  logic                 rdy_s [CORDIC_STAGES+1];

  logic signed [DW-1:0] decl_r, decl_nxt, cfg_val;
  logic [HW-1:0]        heading;

  // Declination is saturated to +/-180 degrees when written.
  assign cfg_val = cfg_wdata;
  always_comb begin
    decl_nxt = cfg_val;
    if (cfg_val > DECL_LIMIT) begin
      decl_nxt = DECL_LIMIT;
    end else if (cfg_val < -DECL_LIMIT) begin
      decl_nxt = -DECL_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= '0;
    end else if (cfg_we) begin
      decl_r <= decl_nxt;
    end
  end

  // Input stage.
  chead_prep #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .W           (W)
  ) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .up_vld (in_tvalid),
    .up_rdy (in_tready),
    .x_i    (in_tdata[SAMPLE_BITS-1:0]),
    .y_i    (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .dn_rdy (rdy_s[0]),
    .ctl_o  (ctl_s[0]),
    .x_o    (x_s[0]),
    .y_o    (y_s[0]),
    .z_o    (z_s[0])
  );

  // Rotation stages.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    chead_cordic_stage #(
      .STAGE (k),
      .W     (W)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_s[k]),
      .up_rdy (rdy_s[k]),
      .x_i    (x_s[k]),
      .y_i    (y_s[k]),
      .z_i    (z_s[k]),
      .dn_rdy (rdy_s[k+1]),
      .ctl_o  (ctl_s[k+1]),
      .x_o    (x_s[k+1]),
      .y_o    (y_s[k+1]),
      .z_o    (z_s[k+1])
    );
  end

  // Rounding, declination and wrap.
  chead_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl_s[CORDIC_STAGES]),
    .up_rdy    (rdy_s[CORDIC_STAGES]),
    .z_i       (z_s[CORDIC_STAGES]),
    .decl_i    (decl_r),
    .dn_rdy    (out_tready),
    .out_vld   (out_tvalid),
    .heading_o (heading)
  );

  assign out_tdata = {1'b0, heading};

endmodule

FILE: rtl/core/chead_checker.sv
// ----------------------------------------------------------------------------
// Compass heading port checker
// Watches the top-level ports for range, flow and reset behavior.
// ----------------------------------------------------------------------------
`include "compass_heading_from_xy_defines.svh"

module chead_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result keeps its value.
  `CHEAD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // Every heading lies within one turn and the pad bit is clear.
  `CHEAD_ASSERT_SAME(a_range, clk, rst_n, out_tvalid, out_tdata <= 16'd23040, "heading out of range")

  // With the output stage empty, the whole pipeline can take an item.
  `CHEAD_ASSERT_SAME(a_ready, clk, rst_n, !out_tvalid, in_tready, "input stalled with empty output")

  // Reset empties the pipeline.
  `CHEAD_ASSERT_ALWAYS_NEXT(a_reset, clk, !rst_n, !out_tvalid, "result after reset")

endmodule

bind compass_heading_from_xy chead_checker u_chead_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading block testbench
// Streams signed X,Y magnetometer pairs through the heading block under random
// idling and stalls on both sides, predicts every heading with a bit-accurate
// vectoring CORDIC of its own, and compares each result item in order. The
// declination register is swept through its extremes and saturating values.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_STAGES     = chead_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY        = NUM_STAGES + 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_SET  = 150;
  localparam int NUM_SETS       = 9;
  localparam int CALM_SET       = 3;

  // Angle constants: FINE_ values in 1/16384 degree, TURN and DECL_MAX in 1/64 degree.
  localparam longint FINE_DEG90  = 90 * 64 * 256;
  localparam longint FINE_DEG180 = 180 * 64 * 256;
  localparam longint TURN        = 23040;
  localparam longint DECL_MAX    = 11520;

  // atan(2^-i) in 1/16384 degree.
  localparam longint ATAN_FINE [0:23] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  typedef struct {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic        [14:0] heading;
  } heading_rec_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [14:0] cfg_wdata  = '0;

  logic [23:0]        pending_samples[$];
  heading_rec_t       heading_due[$];
  logic signed [14:0] decl_now       = '0;
  logic               item_taken     = 1'b0;
  logic               calm           = 1'b0;
  int                 mismatch_count = 0;
  int                 stall_cycles   = 0;

  compass_heading_from_xy #(
    .CORDIC_STAGES(NUM_STAGES),
    .SAMPLE_BITS  (12)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Heading in 1/64 degree for one X,Y pair under a given declination.
  function automatic logic [14:0] predict_heading(input logic signed [11:0] xs,
                                                  input logic signed [11:0] ys,
                                                  input logic signed [14:0] decl);
    longint vx, vy, z, dx, dy, ang, d, h;
    int i;
    vx = xs;
    vy = ys;
    z  = 0;
    if (vx == 0 && vy == 0) begin
      z = 0;
    end else if (vy == 0) begin
      z = (vx > 0) ? 0 : FINE_DEG180;
    end else if (vx == 0) begin
      z = (vy > 0) ? FINE_DEG90 : -FINE_DEG90;
    end else begin
      vx = vx <<< 24;
      vy = vy <<< 24;
      // Fold the left half-plane onto the right one.
      if (vx < 0) begin
        z  = (vy >= 0) ? FINE_DEG180 : -FINE_DEG180;
        vx = -vx;
        vy = -vy;
      end
      for (i = 0; i < NUM_STAGES && i < 24; i++) begin
        dx = vx >>> i;
        dy = vy >>> i;
        if (vy < 0) begin
          vx = vx - dy;
          vy = vy + dx;
          z  = z - ATAN_FINE[i];
        end else begin
          vx = vx + dy;
          vy = vy - dx;
          z  = z + ATAN_FINE[i];
        end
      end
    end
    // Round to 1/64 degree, ties upward.
    ang = (z + 128) >>> 8;
    d = decl;
    if (d > DECL_MAX) d = DECL_MAX;
    if (d < -DECL_MAX) d = -DECL_MAX;
    h = ang + d;
    if (h < 0) h = h + TURN;
    if (h > TURN) h = h - TURN;
    return h[14:0];
  endfunction

  // One random sample pair, weighted toward axes, extremes, small vectors and the -X axis.
  function automatic logic [23:0] random_sample();
    logic signed [11:0] xs, ys;
    int kind;
    int corner [0:5];
    corner = '{-2048, -2047, -1, 0, 1, 2047};
    kind = $urandom_range(0, 99);
    xs = 12'($urandom);
    ys = 12'($urandom);
    if (kind >= 60 && kind < 70) begin
      xs = 12'($signed($urandom_range(0, 6)) - 3);
      ys = 12'($signed($urandom_range(0, 6)) - 3);
    end else if (kind >= 70 && kind < 80) begin
      if ($urandom_range(0, 1) == 1) xs = '0;
      else ys = '0;
    end else if (kind >= 80 && kind < 90) begin
      xs = 12'(corner[$urandom_range(0, 5)]);
      ys = 12'(corner[$urandom_range(0, 5)]);
    end else if (kind >= 90) begin
      // Left half-plane close to the negative X axis.
      xs = 12'(-$signed($urandom_range(1, 2048)));
      ys = 12'($signed($urandom_range(0, 2)) - 1);
    end
    return {ys, xs};
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Wait until no item is queued or in flight, then let the pipeline settle.
  task automatic wait_idle();
    while (pending_samples.size() > 0 || in_tvalid || heading_due.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_declination(input logic [14:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    decl_now  = value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Input driver: offers the next queued item once the current one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || item_taken)) begin
      if (pending_samples.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        in_tdata  <= pending_samples.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result backpressure.
  always @(negedge clk) begin
    if (rst_n) out_tready <= calm || ($urandom_range(0, 99) >= 9);
  end

  // Monitor: predicts on input acceptance, checks on result acceptance.
  always @(posedge clk) begin : monitor
    heading_rec_t due;
    if (rst_n) begin
      item_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        due.x       = in_tdata[11:0];
        due.y       = in_tdata[23:12];
        due.heading = predict_heading(in_tdata[11:0], in_tdata[23:12], decl_now);
        heading_due.push_back(due);
      end
      if (out_tvalid && out_tready) begin
        if (heading_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result item %0d", out_tdata[14:0]));
        end else begin
          due = heading_due.pop_front();
          if (out_tdata[14:0] !== due.heading)
            report_mismatch($sformatf("x=%0d y=%0d decl=%0d heading %0d, expected %0d",
                                      due.x, due.y, decl_now, out_tdata[14:0],
                                      due.heading));
          if (out_tdata[15] !== 1'b0)
            report_mismatch($sformatf("x=%0d y=%0d pad bit is %b",
                                      due.x, due.y, out_tdata[15]));
        end
      end
      // Watchdog on cycles in which neither side moves an item.
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int set_idx;
    int n;
    logic [14:0] decl_set [0:NUM_SETS-1];
    logic signed [11:0] edge_x [0:20];
    logic signed [11:0] edge_y [0:20];

    edge_x = '{0, 5, -5, 0, 0, 2047, -2048, 0, 0, 2047, -2048,
               -2048, 2047, 1, -1, -1, 1, -1, -2048, -2048, 100};
    edge_y = '{0, 0, 0, 5, -5, 0, 0, 2047, -2048, 2047, -2048,
               2047, -2048, 1, -1, 1, -1, 0, -1, 1, -1};
    // Declination sweep: both limits, saturating values, random values, zero.
    decl_set[0] = 15'(11520);
    decl_set[1] = 15'(-11520);
    decl_set[2] = 15'(16383);
    decl_set[3] = 15'(-16384);
    decl_set[4] = 15'(11521);
    decl_set[5] = 15'(-11521);
    decl_set[6] = 15'($urandom_range(0, 32767));
    decl_set[7] = 15'($signed($urandom_range(0, 23040)) - 11520);
    decl_set[8] = 15'(0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass at the reset declination: origin, axes, extremes, half-plane edges.
    for (n = 0; n < 21; n++) pending_samples.push_back({edge_y[n], edge_x[n]});
    wait_idle();

    // Random sets, each under its own declination.
    for (set_idx = 0; set_idx < NUM_SETS; set_idx++) begin
      write_declination(decl_set[set_idx]);
      calm = (set_idx == CALM_SET);
      // Origin and X-axis items, on the wrap boundary at some declinations.
      pending_samples.push_back({12'sd0, -12'sd1});
      pending_samples.push_back({12'sd0, 12'sd1});
      pending_samples.push_back({12'sd0, 12'sd0});
      for (n = 0; n < ITEMS_PER_SET; n++) pending_samples.push_back(random_sample());
      wait_idle();
      calm = 1'b0;
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: compass_heading_from_xy.f
+incdir+rtl/core
rtl/core/chead_pkg.sv
rtl/core/chead_prep.sv
rtl/core/chead_cordic_stage.sv
rtl/core/chead_finish.sv
rtl/core/compass_heading_from_xy.sv
rtl/core/chead_checker.sv
tb/tb_top.sv
